// ----- sv/msm_pkg.sv -----
// Shared types and constants for the multi-stack shared memory block.
`default_nettype none

package msm_pkg;

  // Fixed field widths
  localparam int FuncW      = 2;
  localparam int SnW        = 3;
  localparam int StatusW    = 2;
  localparam int ElemW      = 32;
  localparam int CntW       = 7;   // region size and fill level
  localparam int StkCfgW    = 4;   // stack count register
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 7;
  localparam int StoreAddrW = 6;   // covers the largest supported store

  // Parameter defaults
  localparam int DefMemoryDepth = 64;
  localparam int DefMaxStacks   = 8;
  localparam int DefDataWidth   = 32;
  localparam int QueueDepth     = 2;

  // Register reset values
  localparam logic [StkCfgW-1:0] StackCountRst = 4'd1;
  localparam logic [CntW-1:0]    RegionSizeRst = 7'd64;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgStackCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRegionSize = 1'd1;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_DUMP = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_STACK = 2'd3
  } status_e;

  // What the back end has to do with a queued command
  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,  // single result, no memory access
    KIND_PUSH   = 2'd1,
    KIND_POP    = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [SnW-1:0]        sn;
    logic [StoreAddrW-1:0] addr;   // write/read address, or dump base
    logic [CntW-1:0]       count;  // dump length
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/msm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/msm_fifo.sv -----
// Small command queue between the front and back ends.
`default_nettype none

module msm_fifo #(
  parameter int Width = 8,
  parameter int Depth = msm_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] pop_data_o,
  output logic                  valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/msm_front.sv -----
// Front end: config registers, fill levels, command classification.
`default_nettype none

module msm_front #(
  parameter int MemoryDepth = msm_pkg::DefMemoryDepth,
  parameter int MaxStacks   = msm_pkg::DefMaxStacks
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [msm_pkg::FuncW-1:0]    func_i,
  input  wire logic [msm_pkg::SnW-1:0]      stack_number_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [msm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [msm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output msm_pkg::cmd_t                     q_cmd_o
);

  // Stack count register is 4 bits, stack number 3 bits
  localparam int StkLim   = (MaxStacks < 15) ? MaxStacks : 15;
  localparam int NumFill  = (MaxStacks < 8) ? MaxStacks : 8;
  localparam int StkIdxW  = (StkLim > 1) ? $clog2(StkLim) : 1;
  localparam int FillIdxW = (NumFill > 1) ? $clog2(NumFill) : 1;
  localparam int BaseW    = msm_pkg::SnW + msm_pkg::CntW;

  logic [msm_pkg::StkCfgW-1:0] stk_cfg_q;
  logic [msm_pkg::CntW-1:0]    region_q;
  logic [msm_pkg::CntW-1:0]    fill_q [NumFill];

  // Largest region per stack count
  logic [msm_pkg::CntW-1:0] lim_tbl [StkLim];
  for (genvar s = 0; s < StkLim; s++) begin : g_lim
    localparam int Lim = MemoryDepth / (s + 1);
    assign lim_tbl[s] = msm_pkg::CntW'(Lim);
  end

  logic [msm_pkg::StkCfgW-1:0] stk, stk_m1;
  logic [msm_pkg::CntW-1:0]    lim, cap, fill;
  logic                        sn_ok, accept;
  logic [FillIdxW-1:0]         fidx;
  logic [BaseW-1:0]            base, top;
  msm_pkg::cmd_t               cmd;
  logic                        enq;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    stk = stk_cfg_q;
    if (stk == '0) begin
      stk = msm_pkg::StkCfgW'(1);
    end else if (stk > msm_pkg::StkCfgW'(StkLim)) begin
      stk = msm_pkg::StkCfgW'(StkLim);
    end
    stk_m1 = stk - 1'b1;
    lim    = lim_tbl[stk_m1[StkIdxW-1:0]];
    cap    = region_q;
    if (cap == '0) begin
      cap = msm_pkg::CntW'(1);
    end else if (cap > lim) begin
      cap = lim;
    end

    sn_ok = ({1'b0, stack_number_i} < stk);
    fidx  = sn_ok ? stack_number_i[FillIdxW-1:0] : '0;
    fill  = fill_q[fidx];
    if (fill > cap) begin
      fill = cap;
    end
    base = BaseW'(stack_number_i) * BaseW'(cap);
    top  = base + BaseW'(fill);

    cmd        = '0;
    cmd.sn     = stack_number_i;
    cmd.kind   = msm_pkg::KIND_REPORT;
    cmd.status = msm_pkg::ST_OK;
    enq        = 1'b1;
    if (!sn_ok) begin
      cmd.status = msm_pkg::ST_BAD_STACK;
      enq        = (func_i inside {msm_pkg::FUNC_PUSH, msm_pkg::FUNC_POP, msm_pkg::FUNC_DUMP});
    end else begin
      case (func_i)
        msm_pkg::FUNC_PUSH: begin
          if (fill >= cap || top >= BaseW'(MemoryDepth)) begin
            cmd.status = msm_pkg::ST_OVERFLOW;
          end else begin
            cmd.kind = msm_pkg::KIND_PUSH;
            cmd.addr = top[msm_pkg::StoreAddrW-1:0];
          end
        end
        msm_pkg::FUNC_POP: begin
          if (fill == '0) begin
            cmd.status = msm_pkg::ST_UNDERFLOW;
          end else begin
            cmd.kind = msm_pkg::KIND_POP;
            cmd.addr = msm_pkg::StoreAddrW'(top - 1'b1);
          end
        end
        msm_pkg::FUNC_DUMP: begin
          if (fill == '0) begin
            cmd.status = msm_pkg::ST_UNDERFLOW;
          end else begin
            cmd.kind  = msm_pkg::KIND_DUMP;
            cmd.addr  = base[msm_pkg::StoreAddrW-1:0];
            cmd.count = fill;
          end
        end
        default: enq = 1'b0;  // undefined op, dropped
      endcase
    end
  end

  // An invalid stack number with op code 3 is dropped as well
  assign q_push_o = accept && enq;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_cfg_q <= msm_pkg::StackCountRst;
      region_q  <= msm_pkg::RegionSizeRst;
      for (int i = 0; i < NumFill; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msm_pkg::CfgStackCount: stk_cfg_q <= cfg_data_i[msm_pkg::StkCfgW-1:0];
        msm_pkg::CfgRegionSize: region_q  <= cfg_data_i;
        default: ;
      endcase
      // any write empties every stack
      for (int i = 0; i < NumFill; i++) begin
        fill_q[i] <= '0;
      end
    end else if (q_push_o) begin
      if (cmd.kind == msm_pkg::KIND_PUSH) begin
        fill_q[fidx] <= fill + 1'b1;
      end else if (cmd.kind == msm_pkg::KIND_POP) begin
        fill_q[fidx] <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/msm_back.sv -----
// Back end: executes queued commands against the store, drives results.
`default_nettype none

module msm_back #(
  parameter int DataWidth = msm_pkg::DefDataWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire msm_pkg::cmd_t                  q_cmd_i,
  input  wire logic [DataWidth-1:0]           q_value_i,
  output logic                                q_pop_o,
  output logic                                ram_we_o,
  output logic      [msm_pkg::StoreAddrW-1:0] ram_waddr_o,
  output logic      [DataWidth-1:0]           ram_wdata_o,
  output logic                                ram_re_o,
  output logic      [msm_pkg::StoreAddrW-1:0] ram_raddr_o,
  input  wire logic [DataWidth-1:0]           ram_rdata_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [msm_pkg::StatusW-1:0]    status_o,
  output logic signed [msm_pkg::ElemW-1:0]    element_o,
  output logic      [msm_pkg::SnW-1:0]        stack_echo_o,
  output logic                                last_o
);

  logic                       out_valid_q;
  logic                       pend_q;        // read data is on the store output
  logic [msm_pkg::CntW-1:0]   idx_q;         // dump position
  logic [msm_pkg::SnW-1:0]    pend_sn_q;
  logic                       pend_last_q;
  msm_pkg::status_e           status_q;
  logic signed [msm_pkg::ElemW-1:0] elem_q;
  logic [msm_pkg::SnW-1:0]    echo_q;
  logic                       last_q;

  logic is_read, out_free, load_now, take, dump_last;

  always_comb begin
    is_read   = (q_cmd_i.kind == msm_pkg::KIND_POP) || (q_cmd_i.kind == msm_pkg::KIND_DUMP);
    out_free  = !out_valid_q || out_ready_i;
    load_now  = pend_q && out_free;
    // a read may issue as the pending beat leaves; others wait for it
    take      = q_valid_i && (is_read ? (!pend_q || load_now) : (out_free && !pend_q));
    dump_last = ((idx_q + 1'b1) == q_cmd_i.count);
    q_pop_o   = take && ((q_cmd_i.kind != msm_pkg::KIND_DUMP) || dump_last);

    ram_we_o    = take && (q_cmd_i.kind == msm_pkg::KIND_PUSH);
    ram_waddr_o = q_cmd_i.addr;
    ram_wdata_o = q_value_i;
    ram_re_o    = take && is_read;
    ram_raddr_o = (q_cmd_i.kind == msm_pkg::KIND_DUMP)
                ? q_cmd_i.addr + idx_q[msm_pkg::StoreAddrW-1:0]
                : q_cmd_i.addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (take && is_read) begin
        pend_q <= 1'b1;
      end else if (load_now) begin
        pend_q <= 1'b0;
      end
      if (take && (q_cmd_i.kind == msm_pkg::KIND_DUMP)) begin
        idx_q <= dump_last ? '0 : idx_q + 1'b1;
      end
      if (load_now || (take && !is_read)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_read) begin
      pend_sn_q   <= q_cmd_i.sn;
      pend_last_q <= (q_cmd_i.kind == msm_pkg::KIND_POP) || dump_last;
    end
    if (load_now) begin
      status_q <= msm_pkg::ST_OK;
      elem_q   <= msm_pkg::ElemW'($signed(ram_rdata_i));
      echo_q   <= pend_sn_q;
      last_q   <= pend_last_q;
    end else if (take && !is_read) begin
      status_q <= q_cmd_i.status;
      elem_q   <= '0;
      echo_q   <= q_cmd_i.sn;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign element_o    = elem_q;
  assign stack_echo_o = echo_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- sv/multi_stack_shared_memory.sv -----
// Top level of the multi-stack shared memory block.
`default_nettype none

// Several stacks share one element store of MEMORY_DEPTH words, cut into
// equal regions (stack n owns n*cap .. n*cap+cap-1). Each input beat names a
// stack and asks for push, pop or dump; push gives one result (ok or
// overflow), pop one result carrying the removed element, dump one result per
// stored element bottom to top with last set on the final one. Empty pop or
// dump reports underflow, a stack number at or above the stacks in use
// reports invalid stack, op code 3 is dropped with no result. A write to
// either config register empties every stack at once (store contents are
// kept, no clearing pass). The front end classifies a beat and updates the
// fill level in the cycle it is accepted and can take one beat per cycle
// while the 2-entry command queue has room. The back end drives the store's
// write and read ports: a push or a report is one queue entry, a pop one store
// read, a dump one read per element; a new read can issue as the pending one
// leaves, while a push or report waits for it. Results pass the queue and the
// result register, reads also the store's read register, plus any output stall.
module multi_stack_shared_memory #(
  parameter int MEMORY_DEPTH = msm_pkg::DefMemoryDepth,
  parameter int MAX_STACKS   = msm_pkg::DefMaxStacks,
  parameter int DATA_WIDTH   = msm_pkg::DefDataWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input beats
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [msm_pkg::FuncW-1:0]      func_i,
  input  wire logic [msm_pkg::SnW-1:0]        stack_number_i,
  input  wire logic signed [msm_pkg::ElemW-1:0] push_value_i,
  // result beats
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [msm_pkg::StatusW-1:0]    status_o,
  output logic signed [msm_pkg::ElemW-1:0]    element_o,
  output logic      [msm_pkg::SnW-1:0]        stack_echo_o,
  output logic                                last_o,
  // config writes
  input  wire logic                           cfg_we_i,
  input  wire logic [msm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [msm_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AddrW  = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
  localparam int QWidth = $bits(msm_pkg::cmd_t) + DATA_WIDTH;

  // front -> queue
  logic               q_push, q_full;
  msm_pkg::cmd_t      f_cmd;
  // queue -> back
  logic               q_valid, q_pop;
  logic [QWidth-1:0]  q_head;
  msm_pkg::cmd_t      b_cmd;
  logic [DATA_WIDTH-1:0] b_value;
  // back <-> store
  logic                           ram_we, ram_re;
  logic [msm_pkg::StoreAddrW-1:0] ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]          ram_wdata, ram_rdata;

  msm_front #(
    .MemoryDepth (MEMORY_DEPTH),
    .MaxStacks   (MAX_STACKS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .stack_number_i (stack_number_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (f_cmd)
  );

  // push value rides along in its stored width
  msm_fifo #(
    .Width (QWidth),
    .Depth (msm_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({f_cmd, DATA_WIDTH'(push_value_i)}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_head),
    .valid_o     (q_valid)
  );

  assign b_cmd   = q_head[QWidth-1:DATA_WIDTH];
  assign b_value = q_head[DATA_WIDTH-1:0];

  msm_back #(
    .DataWidth (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (b_cmd),
    .q_value_i    (b_value),
    .q_pop_o      (q_pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .element_o    (element_o),
    .stack_echo_o (stack_echo_o),
    .last_o       (last_o)
  );

  msm_ram #(
    .Width (DATA_WIDTH),
    .Depth (MEMORY_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // queue is never written while full
  a_no_q_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command queue written while full");

  // store accesses stay inside the store
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= msm_pkg::StoreAddrW'(MEMORY_DEPTH - 1)))
    else $error("store write out of range");

  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (ram_raddr <= msm_pkg::StoreAddrW'(MEMORY_DEPTH - 1)))
    else $error("store read out of range");

  // error results are single beats with a zero element
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != msm_pkg::ST_OK)) |-> (last_o && (element_o == '0)))
    else $error("error result not a single zero beat");

endmodule

`default_nettype wire

// ----- dv/msm_checker.sv -----
// Scoreboard for the multi-stack shared memory: shadow stacks, expected results, beat compare.
module msm_checker
  import msm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [FuncW-1:0]        func_i,
  input  logic [SnW-1:0]          stack_number_i,
  input  logic signed [ElemW-1:0] push_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [StatusW-1:0]      status_i,
  input  logic signed [ElemW-1:0] element_i,
  input  logic [SnW-1:0]          stack_echo_i,
  input  logic                    last_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_count_o
);

  localparam int MemDepth  = DefMemoryDepth;
  localparam int MaxStacks = DefMaxStacks;

  typedef struct {
    status_e                 status;
    logic signed [ElemW-1:0] element;
    logic [SnW-1:0]          stack;
    logic                    last;
  } stack_result_t;

  logic [ElemW-1:0]   shadow_mem  [MemDepth];
  logic [CntW-1:0]    shadow_fill [MaxStacks];
  logic [StkCfgW-1:0] stack_count_q;
  logic [CntW-1:0]    region_size_q;
  stack_result_t      expected_results [$];

  function automatic int stacks_in_effect();
    int n;
    n = stack_count_q;
    if (n < 1) n = 1;
    if (n > MaxStacks) n = MaxStacks;
    return n;
  endfunction

  function automatic int region_in_effect(int stacks);
    int c;
    c = region_size_q;
    if (c < 1) c = 1;
    if (c > MemDepth / stacks) c = MemDepth / stacks;
    return c;
  endfunction

  task automatic queue_result(status_e st, logic signed [ElemW-1:0] el,
                              logic [SnW-1:0] sn, logic lst);
    stack_result_t r;
    r.status  = st;
    r.element = el;
    r.stack   = sn;
    r.last    = lst;
    expected_results.push_back(r);
  endtask

  // Apply one accepted beat to the shadow stacks and queue what it must produce.
  task automatic predict_stack_op(logic [FuncW-1:0] op, logic [SnW-1:0] sn,
                                  logic signed [ElemW-1:0] value);
    int stacks, cap, base, fill;
    stacks = stacks_in_effect();
    cap    = region_in_effect(stacks);
    if (op != FUNC_PUSH && op != FUNC_POP && op != FUNC_DUMP) return;
    if (sn >= stacks) begin
      queue_result(ST_BAD_STACK, '0, sn, 1'b1);
      return;
    end
    base = sn * cap;
    fill = shadow_fill[sn];
    if (fill > cap) fill = cap;
    if (op == FUNC_PUSH) begin
      if (fill >= cap || base + fill >= MemDepth) begin
        queue_result(ST_OVERFLOW, '0, sn, 1'b1);
      end else begin
        shadow_mem[base + fill] = value;
        shadow_fill[sn] = CntW'(fill + 1);
        queue_result(ST_OK, '0, sn, 1'b1);
      end
    end else if (fill == 0) begin
      queue_result(ST_UNDERFLOW, '0, sn, 1'b1);
    end else if (op == FUNC_POP) begin
      queue_result(ST_OK, shadow_mem[base + fill - 1], sn, 1'b1);
      shadow_fill[sn] = CntW'(fill - 1);
    end else begin
      for (int i = 0; i < fill; i++) begin
        queue_result(ST_OK, shadow_mem[base + i], sn, i == fill - 1);
      end
    end
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    if (!rst_ni) begin
      stack_count_q = StackCountRst;
      region_size_q = RegionSizeRst;
      foreach (shadow_fill[i]) shadow_fill[i] = '0;
      expected_results.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // a result can never leave in the cycle its input is taken, so compare first
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual status %0d element %0d",
                   $time, status_i, element_i);
          mismatch_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("element", want.element, element_i);
          check_field("stack_echo", want.stack, stack_echo_i);
          check_field("last", want.last, last_i);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStackCount) stack_count_q = cfg_data_i[StkCfgW-1:0];
        else                            region_size_q = cfg_data_i[CntW-1:0];
        foreach (shadow_fill[i]) shadow_fill[i] = '0;
      end
      if (in_valid_i && in_ready_i) begin
        predict_stack_op(func_i, stack_number_i, push_value_i);
      end
      pending_count_o = expected_results.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the multi-stack shared memory: stimulus, back-pressure and verdict.
module tb_top;
  import msm_pkg::*;

  // Op code 3 has no meaning; the block drops it without a result.
  localparam logic [FuncW-1:0] FuncNone = 2'd3;

  // Slowest correct run: ~430 beats, each a dump of up to 64 results, each
  // result held up by the receiver's longest stall. The limit is several
  // times that worst case.
  localparam int CycleLimit  = 4_000_000;
  // Pause after the last expected result: a beat with no expected result may
  // still be in the 2-entry queue / back end, so give it margin.
  localparam int DrainCycles = 12;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 32;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [FuncW-1:0]        func_i;
  logic [SnW-1:0]          stack_number_i;
  logic signed [ElemW-1:0] push_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [StatusW-1:0]      status_o;
  logic signed [ElemW-1:0] element_o;
  logic [SnW-1:0]          stack_echo_o;
  logic                    last_o;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_data_i;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int active_stacks = 1;  // stacks in effect, for steering stack numbers
  bit quiet_phase = 1'b0; // no idling on either side while set

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  multi_stack_shared_memory u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .stack_number_i (stack_number_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .element_o      (element_o),
    .stack_echo_o   (stack_echo_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  msm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .stack_number_i   (stack_number_i),
    .push_value_i     (push_value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .element_i        (element_o),
    .stack_echo_i     (stack_echo_o),
    .last_i           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("multi_stack_shared_memory: mismatch");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Receiver back-pressure: one assignment per falling edge, stalls start at random.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Mostly a stack in use, now and then any stack number (may be invalid).
  function automatic logic [SnW-1:0] pick_stack();
    if ($urandom_range(0, 9) != 0) return SnW'($urandom_range(0, active_stacks - 1));
    return SnW'($urandom_range(0, (1 << SnW) - 1));
  endfunction

  function automatic logic signed [ElemW-1:0] push_word();
    if ($urandom_range(0, 7) != 0) return ElemW'($urandom);
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // One input beat. Valid goes up at a falling edge and holds until the
  // beat is taken; back-to-back beats keep valid high with no dip.
  task automatic send_beat(logic [FuncW-1:0] op, logic [SnW-1:0] sn,
                           logic signed [ElemW-1:0] value);
    int pause;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    func_i         <= op;
    stack_number_i <= sn;
    push_value_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    pause = idle_len();
    if (pause > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (pause - 1) @(negedge clk_i);
    end
  endtask

  // Set both registers once the block has drained. The write empties all
  // stacks, so it must not overlap live traffic.
  task automatic program_regions(logic [CfgDataW-1:0] count_word,
                                 logic [CfgDataW-1:0] size_word);
    int n;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgStackCount;
    cfg_data_i <= count_word;
    @(negedge clk_i);
    cfg_idx_i  <= CfgRegionSize;
    cfg_data_i <= size_word;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    // zero acts as one stack, anything past the maximum as the maximum
    n = count_word[StkCfgW-1:0];
    if (n < 1) n = 1;
    if (n > DefMaxStacks) n = DefMaxStacks;
    active_stacks = n;
  endtask

  initial begin
    int pick, burst, done;
    logic [SnW-1:0] sn;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_PUSH;
    stack_number_i = '0;
    push_value_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgStackCount;
    cfg_data_i     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed: reset setting, one stack of 64 ----
    send_beat(FUNC_POP,  3'd0, 32'sd0);          // pop of an empty stack
    send_beat(FUNC_DUMP, 3'd0, -32'sd1);         // dump of an empty stack
    send_beat(FUNC_PUSH, 3'd0, 32'sh8000_0000);  // most negative
    send_beat(FUNC_PUSH, 3'd0, 32'sh7fff_ffff);  // most positive
    send_beat(FUNC_PUSH, 3'd0, 32'sd0);
    send_beat(FUNC_PUSH, 3'd0, -32'sd1);
    send_beat(FUNC_DUMP, 3'd0, 32'sd0);          // four beats, bottom first
    send_beat(FUNC_POP,  3'd0, 32'sd0);
    send_beat(FUNC_PUSH, 3'd1, 32'sh1234_5678);  // stack number past the count
    send_beat(FUNC_POP,  3'd7, 32'sd0);
    send_beat(FuncNone,  3'd0, 32'sd0);          // dropped op code
    send_beat(FuncNone,  3'd7, -32'sd1);
    send_beat(FUNC_DUMP, 3'd7, 32'sd0);

    // eight stacks of one entry each, overflow on the second push
    program_regions(7'd8, 7'd1);
    send_beat(FUNC_PUSH, 3'd0, 32'shaaaa_aaaa);
    send_beat(FUNC_PUSH, 3'd0, 32'sh5555_5555);
    send_beat(FUNC_PUSH, 3'd7, 32'sh5555_5555);
    send_beat(FUNC_DUMP, 3'd7, 32'sd0);
    send_beat(FUNC_POP,  3'd0, 32'sd0);
    send_beat(FUNC_POP,  3'd0, 32'sd0);

    // zero count and zero size both act as one
    program_regions(7'd0, 7'd0);
    send_beat(FUNC_PUSH, 3'd0, 32'sh0f0f_0f0f);
    send_beat(FUNC_PUSH, 3'd0, 32'shf0f0_f0f0);
    send_beat(FUNC_PUSH, 3'd1, 32'sd0);

    // count and size past their limits clamp to 8 stacks of 8
    program_regions(7'h7f, 7'h7f);
    send_beat(FUNC_PUSH, 3'd7, 32'sh0000_0001);
    send_beat(FUNC_DUMP, 3'd7, 32'sd0);
    send_beat(FUNC_POP,  3'd3, 32'sd0);

    // ---- random phases ----
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       program_regions(7'd8, 7'd8);
        1:       program_regions(7'd1, 7'd64);
        2:       program_regions(7'd2, 7'd100);
        default: program_regions(CfgDataW'($urandom_range(0, 127)),
                                 CfgDataW'($urandom_range(0, 127)));
      endcase
      quiet_phase = (ph == 3) || ($urandom_range(0, 4) == 0);
      done = 0;
      while (done < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // run of pushes to one stack, long ones reach the region end
          burst = ($urandom_range(0, 2) == 0) ? $urandom_range(60, 66)
                                              : $urandom_range(2, 12);
          sn = pick_stack();
          repeat (burst) send_beat(FUNC_PUSH, sn, push_word());
          done += burst;
        end else if (pick < 52) begin
          send_beat(FUNC_PUSH, pick_stack(), push_word());
          done++;
        end else if (pick < 77) begin
          send_beat(FUNC_POP, pick_stack(), ElemW'($urandom));
          done++;
        end else if (pick < 88) begin
          send_beat(FUNC_DUMP, pick_stack(), ElemW'($urandom));
          done++;
        end else begin
          // noise: dropped op, not counted
          send_beat(FuncNone, SnW'($urandom_range(0, (1 << SnW) - 1)), ElemW'($urandom));
        end
      end
    end

    // ---- drain and verdict ----
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_stack_shared_memory: match");
    end else begin
      $display("multi_stack_shared_memory: mismatch");
    end
    $finish;
  end

endmodule
